// ===== rtl/mmfe_pkg.sv =====
// Package for the modified Miller frame encoder: request payload types,
// queue entry type and symbol codes. No dependencies.
package mmfe_pkg;

    // Symbol codes, inverted polarity
    localparam logic [1:0] SYM_X = 2'h2;
    localparam logic [1:0] SYM_Y = 2'h0;
    localparam logic [1:0] SYM_Z = 2'h1;

    localparam logic [3:0] MAX_BITS = 4'd8;

    // Widest packed run of one request: 6 pending bits + 8 data + 2 closing symbols (26 bits)
    localparam int WORD_W = 32;
    localparam int TOT_W  = 5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [3:0] bit_count;
        logic       frame_last;
    } src_req_t;

    typedef struct packed {
        logic [7:0] coded_byte;
        logic [3:0] coded_bits;
        logic       frame_end;
        logic       run_last;
    } code_req_t;

    // One classified request as handed from front to back
    typedef struct packed {
        logic [WORD_W-1:0] word;     // packed symbols, bit 0 first
        logic [TOT_W-1:0]  total;    // valid bits in word
        logic [2:0]        nres;     // results to emit, 1..4
        logic              last;     // closes the frame
    } mmfe_entry_t;

endpackage

// ===== rtl/mmfe_front.sv =====
// Front end: accepts source requests, encodes symbols, merges with pending
// bits and hands the packed run to the queue. Depends on mmfe_pkg.
module mmfe_front
    import mmfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        src_valid,
    output logic        src_stall,
    input  src_req_t    src_data,
    input  logic        q_full,
    output logic        q_push,
    output mmfe_entry_t q_entry
);

    logic       frame_open_reg, frame_open_next;
    logic       previous_bit_reg, previous_bit_next;
    logic [7:0] pending_reg, pending_next;
    logic [2:0] pcount_reg, pcount_next;

    logic              accept;
    logic [3:0]        cnt;
    logic              start;
    logic              prev0;
    logic              lastb;
    logic [15:0]       data_syms;
    logic [3:0]        close_syms;
    logic [TOT_W-1:0]  off_data;
    logic [TOT_W-1:0]  off_close;
    logic [TOT_W-1:0]  total;
    logic [WORD_W-1:0] word;
    logic [2:0]        nres;

    assign src_stall = q_full;
    assign accept    = src_valid && !src_stall;

    always_comb
    begin
        logic pb;
        logic [1:0] sym;
        cnt   = (src_data.bit_count > MAX_BITS) ? MAX_BITS : src_data.bit_count;
        start = !frame_open_reg;
        prev0 = start ? 1'b0 : previous_bit_reg;
        lastb = prev0;
        data_syms = '0;
        for (int i = 0; i < 8; i++)
        begin
            pb  = (i == 0) ? prev0 : src_data.data_byte[(i == 0) ? 0 : i - 1];
            sym = src_data.data_byte[i] ? SYM_X : (pb ? SYM_Y : SYM_Z);
            if (4'(i) < cnt)
            begin
                data_syms[2*i +: 2] = sym;
                lastb = src_data.data_byte[i];
            end
        end
        // closing logical 0 then Y
        close_syms = {SYM_Y, (lastb ? SYM_Y : SYM_Z)};
        off_data   = TOT_W'(pcount_reg) + (start ? TOT_W'(2) : TOT_W'(0));
        off_close  = off_data + TOT_W'({cnt, 1'b0});
        total      = off_close + (src_data.frame_last ? TOT_W'(4) : TOT_W'(0));
        word = {{(WORD_W-8){1'b0}}, pending_reg}
             | (start ? ({{(WORD_W-2){1'b0}}, SYM_Z} << pcount_reg) : '0)
             | ({{(WORD_W-16){1'b0}}, data_syms} << off_data)
             | (src_data.frame_last ? ({{(WORD_W-4){1'b0}}, close_syms} << off_close) : '0);
        // round up in one extra bit so a 26-bit closing run does not wrap
        if (src_data.frame_last)
            nres = 3'(({1'b0, total} + 6'd7) >> 3);
        else
            nres = {1'b0, total[4:3]};
    end

    assign q_push        = accept && (nres != 3'd0);
    assign q_entry.word  = word;
    assign q_entry.total = total;
    assign q_entry.nres  = nres;
    assign q_entry.last  = src_data.frame_last;

    always_comb
    begin
        frame_open_next   = frame_open_reg;
        previous_bit_next = previous_bit_reg;
        pending_next      = pending_reg;
        pcount_next       = pcount_reg;
        if (accept)
        begin
            if (src_data.frame_last)
            begin
                frame_open_next   = 1'b0;
                previous_bit_next = 1'b0;
                pending_next      = '0;
                pcount_next       = '0;
            end
            else
            begin
                frame_open_next   = 1'b1;
                previous_bit_next = lastb;
                pending_next      = word[{total[4:3], 3'b000} +: 8];
                pcount_next       = total[2:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg   <= 1'b0;
            previous_bit_reg <= 1'b0;
            pending_reg      <= '0;
            pcount_reg       <= '0;
        end
        else
        begin
            frame_open_reg   <= frame_open_next;
            previous_bit_reg <= previous_bit_next;
            pending_reg      <= pending_next;
            pcount_reg       <= pcount_next;
        end
    end

endmodule

// ===== rtl/mmfe_queue.sv =====
// Small queue between front and back end.
// Depends on mmfe_pkg.
module mmfe_queue
    import mmfe_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  mmfe_entry_t push_entry,
    input  logic        pop,
    output mmfe_entry_t head,
    output logic        not_empty,
    output logic        full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mmfe_entry_t    slots_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign head      = slots_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CW'(DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/mmfe_back.sv =====
// Back end: slices queued symbol runs into output bytes, one per cycle while
// code_stall is low, into a registered output. Depends on mmfe_pkg.
module mmfe_back
    import mmfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  mmfe_entry_t head,
    input  logic        head_valid,
    output logic        pop,
    output logic        code_valid,
    input  logic        code_stall,
    output code_req_t   code_data
);

    logic             out_valid_reg, out_valid_next;
    code_req_t        out_reg, out_next;
    logic [1:0]       idx_reg, idx_next;

    logic             load;
    logic             run_end;
    logic [TOT_W-1:0] remain;

    assign load    = head_valid && (!out_valid_reg || !code_stall);
    assign run_end = ({1'b0, idx_reg} == head.nres - 3'd1);
    assign remain  = head.total - TOT_W'({idx_reg, 3'b000});
    assign pop     = load && run_end;

    always_comb
    begin
        out_next.coded_byte = head.word[{idx_reg, 3'b000} +: 8];
        out_next.coded_bits = (remain >= TOT_W'(8)) ? 4'd8 : remain[3:0];
        out_next.run_last   = run_end;
        out_next.frame_end  = run_end && head.last;

        out_valid_next = out_valid_reg && code_stall;
        idx_next       = idx_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = run_end ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    assign code_valid = out_valid_reg;
    assign code_data  = out_reg;

endmodule

// ===== rtl/modified_miller_frame_encoder.sv =====
// Modified Miller frame encoder, reader to card. Top level; uses mmfe_pkg,
// mmfe_front, mmfe_queue and mmfe_back.
// The first output byte of a request is registered in the queue and then in the back end's output register.
// Throughput: one output byte per cycle from the back end's output register while
// code_stall is low; a full 8-bit request yields two bytes, and the front
// takes a request per cycle while the queue has room.
// Reset (rst_n low, async) clears frame state, queue and output valid.
module modified_miller_frame_encoder
    import mmfe_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    // source requests: up to 8 bits, LSB first
    input  logic      src_valid,
    output logic      src_stall,
    input  src_req_t  src_data,
    // coded bytes: 2-bit symbols packed LSB first
    output logic      code_valid,
    input  logic      code_stall,
    output code_req_t code_data
);

    // The front encodes a whole request combinationally: start Z when a frame
    // opens, one symbol per source bit, and the closing 0 + Y on frame_last.
    // These are merged above the pending partial byte into a packed run
    // (at most 26 bits), which the back end slices into bytes. Requests
    // that complete no byte only update the pending state and skip the queue.
    logic        q_push;
    mmfe_entry_t q_entry;
    logic        q_full;
    logic        q_pop;
    mmfe_entry_t q_head;
    logic        q_not_empty;

    mmfe_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    // Decouples the per-request front from the per-byte back end
    mmfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .not_empty  (q_not_empty),
        .full       (q_full)
    );

    // One byte per cycle while code_stall is low; run_last on the last byte of a request,
    // frame_end also when that request closed the frame
    mmfe_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .head_valid (q_not_empty),
        .pop        (q_pop),
        .code_valid (code_valid),
        .code_stall (code_stall),
        .code_data  (code_data)
    );

endmodule
